FILE: design/sfdd_pkg.sv
// ----------------------------------------------------------------------------
// sfdd_pkg
// shared types and constants for the sensor frame deframer with duplicate
// rejection
// ----------------------------------------------------------------------------
package sfdd_pkg;

	localparam int FrameLen = 20;
	localparam int WordCount = 9;
	localparam int LeWords = 3;
	localparam logic [7:0] LastPos = 8'(FrameLen - 1);
	localparam logic [7:0] IdxMax = 8'hFF;
	localparam logic [3:0] NodeCountReset = 4'd5;
	localparam logic RegNodeCount = 1'b0;

	typedef logic [15:0] word_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_NODE = 2'd1,
		ST_BAD_LEN  = 2'd2,
		ST_SEEN     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] node_id;
		logic [7:0] seq_num;
		word_t      accel_x;
		word_t      accel_y;
		word_t      accel_z;
		word_t      gyro_x;
		word_t      gyro_y;
		word_t      gyro_z;
		word_t      mag_x;
		word_t      mag_y;
		word_t      mag_z;
	} result_t;

	typedef struct packed {
		logic                       bad_node;
		logic                       bad_len;
		logic [7:0]                 node;
		logic [7:0]                 seq;
		word_t [WordCount-1:0]      words;
	} frame_t;

endpackage

FILE: design/sensor_frame_deframer_dedup.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer_dedup
// sensor packet deframer with per-node duplicate sequence rejection
// ----------------------------------------------------------------------------
// One packet byte is taken per beat, one per clock while the result side
// keeps up; a frame whose beat has the end flag is registered in the check
// stage, then in the result register. The per-node last-sequence memory is
// read on that beat and written back as the check stage hands on its result,
// with the written value forwarded to a read of the same node in that cycle.
// Entries are cleared at reset through one valid flop each, so there is no
// clearing pass. item_ready drops only while both the result register and
// the check stage hold undelivered results.
module sensor_frame_deframer_dedup #(
	parameter int NODES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  sfdd_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output sfdd_pkg::result_t   result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

	logic             node_count_sel;
	logic [3:0]       node_count_r_q;
	logic             accept;
	logic             stall;
	sfdd_pkg::frame_t frame;

	assign node_count_sel = (paddr[2] == sfdd_pkg::RegNodeCount);
	assign pready         = 1'b1;
	assign prdata         = node_count_sel ? {28'd0, node_count_r_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_r_q <= sfdd_pkg::NodeCountReset;
		end else if (psel && penable && pwrite && pready && node_count_sel) begin
			node_count_r_q <= pwdata[3:0];
		end
	end

	assign item_ready = !stall;
	assign accept     = item_valid && item_ready;

	sfdd_deframer #(
		.NODES(NODES)
	) u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.node_count (node_count_r_q),
		.frame      (frame)
	);

	sfdd_seq_check #(
		.NODES(NODES),
		.AW   (AW)
	) u_seq_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && item.frame_end),
		.frame        (frame),
		.stall        (stall),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: design/sfdd_deframer.sv
// ----------------------------------------------------------------------------
// sfdd_deframer
// byte counter and word assembly; presents the finished frame on the beat
// that carries the end flag
// ----------------------------------------------------------------------------
module sfdd_deframer #(
	parameter int NODES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  sfdd_pkg::item_t     item,
	input  logic [3:0]          node_count,
	output sfdd_pkg::frame_t    frame
);

	localparam logic [8:0] NodesW = 9'(NODES);

	logic [7:0] byte_idx_q;
	logic [7:0] held_node_q;
	logic [7:0] held_seq_q;
	logic [7:0] pending_q;
	sfdd_pkg::word_t [sfdd_pkg::WordCount-1:0] words_q;

	logic [7:0] node_d;
	logic [7:0] seq_d;
	logic [7:0] pending_d;
	sfdd_pkg::word_t [sfdd_pkg::WordCount-1:0] words_d;
	logic [3:0] widx;

	always_comb begin
		node_d    = held_node_q;
		seq_d     = held_seq_q;
		pending_d = pending_q;
		words_d   = words_q;
		widx      = byte_idx_q[4:1] - 4'd1;
		if (byte_idx_q == 8'd0) begin
			node_d = item.data_byte;
			seq_d  = 8'd0;
		end else if (byte_idx_q == 8'd1) begin
			seq_d = item.data_byte;
		end else if (byte_idx_q <= sfdd_pkg::LastPos) begin
			if (!byte_idx_q[0]) begin
				pending_d = item.data_byte;
			end else if (widx < 4'(sfdd_pkg::LeWords)) begin
				words_d[widx] = {item.data_byte, pending_q};
			end else begin
				words_d[widx] = {pending_q, item.data_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q  <= '0;
			held_node_q <= '0;
			held_seq_q  <= '0;
			pending_q   <= '0;
		end else if (accept) begin
			held_node_q <= node_d;
			held_seq_q  <= seq_d;
			pending_q   <= pending_d;
			if (item.frame_end) begin
				byte_idx_q <= '0;
			end else if (byte_idx_q != sfdd_pkg::IdxMax) begin
				byte_idx_q <= byte_idx_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			words_q <= words_d;
		end
	end

	always_comb begin
		frame.node     = node_d;
		frame.seq      = seq_d;
		frame.words    = words_d;
		frame.bad_len  = byte_idx_q != sfdd_pkg::LastPos;
		frame.bad_node = ({1'b0, node_d} >= {5'd0, node_count}) ||
			({1'b0, node_d} >= NodesW);
	end

endmodule

FILE: design/sfdd_seq_check.sv
// ----------------------------------------------------------------------------
// sfdd_seq_check
// last-sequence memory with read-modify-write, status decision and result
// register
// ----------------------------------------------------------------------------
module sfdd_seq_check #(
	parameter int NODES = 8,
	parameter int AW = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sfdd_pkg::frame_t    frame,
	output logic                stall,
	output logic                result_valid,
	input  logic                result_ready,
	output sfdd_pkg::result_t   result
);

	logic [7:0]       mem_q [NODES];
	logic [NODES-1:0] vld_q;

	logic              s1_valid_q;
	sfdd_pkg::frame_t  frm_s1;
	logic [7:0]        rdata_s1;

	logic              res_valid_q;
	sfdd_pkg::result_t res_q;

	logic              s1_go;
	sfdd_pkg::status_t status;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic              fwd;

	assign s1_go   = !res_valid_q || result_ready;
	assign stall   = s1_valid_q && !s1_go;
	assign wr_addr = frm_s1.node[AW-1:0];
	assign rd_addr = frame.node[AW-1:0];
	assign wr_en   = s1_valid_q && s1_go && (status == sfdd_pkg::ST_OK);
	assign fwd     = wr_en && (wr_addr == rd_addr);

	always_comb begin
		if (frm_s1.bad_node) begin
			status = sfdd_pkg::ST_BAD_NODE;
		end else if (frm_s1.bad_len) begin
			status = sfdd_pkg::ST_BAD_LEN;
		end else if ((frm_s1.seq != 8'd0) && (frm_s1.seq <= rdata_s1)) begin
			status = sfdd_pkg::ST_SEEN;
		end else begin
			status = sfdd_pkg::ST_OK;
		end
	end

	// memory: one write and one read port, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= frm_s1.seq;
		end
		if (load) begin
			if (fwd) begin
				rdata_s1 <= frm_s1.seq;
			end else if (vld_q[rd_addr]) begin
				rdata_s1 <= mem_q[rd_addr];
			end else begin
				rdata_s1 <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load || s1_go) begin
				s1_valid_q <= load;
			end
			if (s1_go) begin
				res_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frm_s1 <= frame;
		end
		if (s1_go && s1_valid_q) begin
			res_q.status  <= status;
			res_q.node_id <= frm_s1.node;
			res_q.seq_num <= frm_s1.seq;
			if (status == sfdd_pkg::ST_OK) begin
				res_q.accel_x <= frm_s1.words[0];
				res_q.accel_y <= frm_s1.words[1];
				res_q.accel_z <= frm_s1.words[2];
				res_q.gyro_x  <= frm_s1.words[3];
				res_q.gyro_y  <= frm_s1.words[4];
				res_q.gyro_z  <= frm_s1.words[5];
				res_q.mag_x   <= frm_s1.words[6];
				res_q.mag_y   <= frm_s1.words[7];
				res_q.mag_z   <= frm_s1.words[8];
			end else begin
				res_q.accel_x <= '0;
				res_q.accel_y <= '0;
				res_q.accel_z <= '0;
				res_q.gyro_x  <= '0;
				res_q.gyro_y  <= '0;
				res_q.gyro_z  <= '0;
				res_q.mag_x   <= '0;
				res_q.mag_y   <= '0;
				res_q.mag_z   <= '0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: design/sfdd_checker.sv
// ----------------------------------------------------------------------------
// sfdd_checker
// port-level checks for the sensor frame deframer
// ----------------------------------------------------------------------------
module sfdd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input sfdd_pkg::result_t result
);

	// a rejected packet shows no sensor data
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != sfdd_pkg::ST_OK) |->
		(result.accel_x == 16'd0) && (result.accel_y == 16'd0) &&
		(result.accel_z == 16'd0) && (result.gyro_x == 16'd0) &&
		(result.gyro_y == 16'd0) && (result.gyro_z == 16'd0) &&
		(result.mag_x == 16'd0) && (result.mag_y == 16'd0) &&
		(result.mag_z == 16'd0))
		else $error("rejected beat carries sensor data");

	// input only backs up behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without result backpressure");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

endmodule

bind sensor_frame_deframer_dedup sfdd_checker u_sfdd_checker (.*);
